// ===== sv/deadline_ordered_timer_queue_top_macros.svh =====
// assertion macros for the deadline ordered timer queue
// used by deadline_ordered_timer_queue_top, expects clock and reset in scope
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define DOTQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DOTQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/dotq_pkg.sv =====
// shared types and constants for the deadline ordered timer queue
// no dependencies
package dotq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_ID_WIDTH    = 16;

   localparam int TIME_W      = 64;
   localparam int FIELD_ID_W  = 16;
   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_FLUSH    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_IMMEDIATE = 3'd1,
      KIND_REJECTED  = 3'd2,
      KIND_EXPIRED   = 3'd3,
      KIND_NONE      = 3'd4,
      KIND_FLUSHED   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_POP_RD,
      ST_POP_CMP,
      ST_RESULT
   } state_type;

endpackage

// ===== sv/dotq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module dotq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/deadline_ordered_timer_queue_top.sv =====
// deadline ordered timer queue: sorted sleeper queue in a ram, one compare unit
// depends on dotq_pkg, dotq_ram and deadline_ordered_timer_queue_top_macros.svh
//
// usage
//   req channel: tuser carries the command (schedule, tick, flush), tdata the time, delay,
//   id and flag. one transfer in at a time; req_tready is high only while idle.
//   rsp channel: tuser carries the result kind, tdata the id and flag, tlast
//   marks the final result of a request.
//   schedule: a zero delay or a full queue goes straight to the result state. an insert
//   walks back from the tail through the ram, reading, comparing and moving each later
//   entry up one slot until the new entry's slot is found and written, then loads the result.
//   tick and flush: each popped entry takes a registered ram read and a deadline
//   compare; a tick that stops on a pending entry reads and compares it as well, then
//   loads the result. an empty queue or an unknown command gives a single none result.
//   the next request is taken in the cycle after the last result is loaded; requests are
//   handled one at a time.
//   reset clears the entry count, head pointer and all control state; the
//   ram needs no clearing since only counted entries are read.
//   when rsp_tready is low the result register holds and the sequencer waits
//   before overwriting it; a new request is taken while the last result waits.
`include "deadline_ordered_timer_queue_top_macros.svh"

module deadline_ordered_timer_queue_top
   import dotq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DEFAULT_ID_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_time[63:0], delay[127:64], sleeper_id[143:128], is_cooperative[144], zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_id[15:0], out_cooperative[16], zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // kind[2:0]
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = CW + 1;
   localparam int KW = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
   localparam int EW = TIME_W + KW + 1;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] rel);
      logic [PW-1:0] sum;
      sum = PW'(head) + PW'(rel);
      if (sum >= PW'(QUEUE_DEPTH)) begin
         sum = sum - PW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] dl_ff, dl_in;
   logic [KW-1:0]     id_ff, id_in;
   logic              coop_ff, coop_in;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;

   logic          have_pend_ff, have_pend_in;
   kind_type      pend_kind_ff, pend_kind_in;
   logic [KW-1:0] pend_id_ff, pend_id_in;
   logic          pend_coop_ff, pend_coop_in;
   logic          pend_last_ff, pend_last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      rsp_kind_ff, rsp_kind_in;
   logic [KW-1:0] rsp_id_ff, rsp_id_in;
   logic          rsp_coop_ff, rsp_coop_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic [TIME_W-1:0] req_now;
   logic [TIME_W-1:0] req_delay;
   logic [KW-1:0]     req_id;
   logic              req_coop;
   logic [TIME_W:0]   sum_full;
   logic [TIME_W-1:0] dl_sat;
   logic [TIME_W-1:0] rd_deadline;
   logic [KW-1:0]     rd_id;
   logic              rd_coop;
   logic              out_free;
   logic              due;
   logic              rsp_single;

   dotq_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_now   = req_tdata[63:0];
   assign req_delay = req_tdata[127:64];
   assign req_id    = req_tdata[128 +: KW];
   assign req_coop  = req_tdata[144];
   assign sum_full  = {1'b0, req_now} + {1'b0, req_delay};
   assign dl_sat    = sum_full[TIME_W] ? '1 : sum_full[TIME_W-1:0];

   assign rd_deadline = rd_data[TIME_W-1:0];
   assign rd_id       = rd_data[TIME_W +: KW];
   assign rd_coop     = rd_data[EW-1];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign due        = (cmd_ff == CMD_FLUSH) || (rd_deadline <= now_ff);
   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      dl_ff        <= dl_in;
      id_ff        <= id_in;
      coop_ff      <= coop_in;
      pos_ff       <= pos_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_coop_ff <= pend_coop_in;
      pend_last_ff <= pend_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_coop_ff  <= rsp_coop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      now_in       = now_ff;
      dl_in        = dl_ff;
      id_in        = id_ff;
      coop_in      = coop_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      have_pend_in = have_pend_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      pend_coop_in = pend_coop_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_coop_in  = rsp_coop_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = req_tuser;
               now_in       = req_now;
               dl_in        = dl_sat;
               id_in        = req_id;
               coop_in      = req_coop;
               have_pend_in = 1'b0;
               pend_id_in   = req_id;
               pend_coop_in = req_coop;
               pend_last_in = 1'b1;
               state_in     = ST_RESULT;
               case (req_tuser)
                  CMD_SCHEDULE: begin
                     if (req_delay == '0) begin
                        pend_kind_in = KIND_IMMEDIATE;
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        pend_kind_in = KIND_REJECTED;
                     end else begin
                        pos_in   = count_ff;
                        state_in = ST_INS_RD;
                     end
                  end
                  CMD_TICK, CMD_FLUSH: begin
                     if (count_ff == '0) begin
                        pend_kind_in = KIND_NONE;
                        pend_id_in   = '0;
                        pend_coop_in = 1'b0;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  default: begin
                     pend_kind_in = KIND_NONE;
                     pend_id_in   = '0;
                     pend_coop_in = 1'b0;
                  end
               endcase
            end
         end

         ST_INS_RD: begin
            if (pos_ff == '0) begin
               wr_en        = 1'b1;
               wr_addr      = phys(head_ff, pos_ff);
               wr_data      = {coop_ff, id_ff, dl_ff};
               count_in     = count_ff + CW'(1);
               pend_kind_in = KIND_ACCEPTED;
               state_in     = ST_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, pos_ff - CW'(1));
               state_in = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, pos_ff);
            if (rd_deadline > dl_ff) begin
               wr_data  = rd_data;
               pos_in   = pos_ff - CW'(1);
               state_in = ST_INS_RD;
            end else begin
               wr_data      = {coop_ff, id_ff, dl_ff};
               count_in     = count_ff + CW'(1);
               pend_kind_in = KIND_ACCEPTED;
               state_in     = ST_RESULT;
            end
         end

         ST_POP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = ST_POP_CMP;
         end

         ST_POP_CMP: begin
            if (due) begin
               if (!have_pend_ff || out_free) begin
                  if (have_pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_id_in    = pend_id_ff;
                     rsp_coop_in  = pend_coop_ff;
                     rsp_last_in  = 1'b0;
                  end
                  have_pend_in = 1'b1;
                  pend_kind_in = (cmd_ff == CMD_FLUSH) ? KIND_FLUSHED : KIND_EXPIRED;
                  pend_id_in   = rd_id;
                  pend_coop_in = rd_coop;
                  head_in      = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
                  count_in     = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     pend_last_in = 1'b1;
                     state_in     = ST_RESULT;
                  end else begin
                     pend_last_in = 1'b0;
                     state_in     = ST_POP_RD;
                  end
               end
            end else begin
               pend_last_in = 1'b1;
               state_in     = ST_RESULT;
               if (!have_pend_ff) begin
                  pend_kind_in = KIND_NONE;
                  pend_id_in   = '0;
                  pend_coop_in = 1'b0;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_id_in    = pend_id_ff;
               rsp_coop_in  = pend_coop_ff;
               rsp_last_in  = pend_last_ff;
               have_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_coop_ff, FIELD_ID_W'(rsp_id_ff)};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // kinds that are always the only result of a request
   assign rsp_single = (rsp_kind_ff == KIND_ACCEPTED) || (rsp_kind_ff == KIND_IMMEDIATE) ||
                       (rsp_kind_ff == KIND_REJECTED) || (rsp_kind_ff == KIND_NONE);

   `DOTQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(QUEUE_DEPTH), "entry count above depth")
   `DOTQ_ASSERT_IMPLY(a_pop_nonempty, state_ff == ST_POP_CMP, count_ff != '0, "pop on empty queue")
   `DOTQ_ASSERT_IMPLY(a_insert_room, state_ff == ST_INS_RD, count_ff != CW'(QUEUE_DEPTH), "insert into full queue")
   `DOTQ_ASSERT_IMPLY(a_insert_pos, state_ff == ST_INS_CMP, pos_ff != '0 && pos_ff <= count_ff, "insert slot out of range")
   `DOTQ_ASSERT_IMPLY(a_single_last, rsp_valid_ff && rsp_single, rsp_last_ff, "single result without last")

endmodule

// ===== tb/deadline_ordered_timer_queue_top_tb.sv =====
// self-checking testbench for deadline_ordered_timer_queue_top
// depends on dotq_pkg and the rtl of the block; keeps its own sorted sleeper list
// and checks every rsp transfer against the results it predicts from req transfers
module deadline_ordered_timer_queue_top_tb
   import dotq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]        CMD_UNKNOWN  = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX     = '1;
   localparam int                RANDOM_ITEMS = 220;
   localparam int                DRAIN_CYCLES = 64;
   localparam int                CYCLE_LIMIT  = 500000;

   typedef struct {
      logic [1:0]            command;
      logic [TIME_W-1:0]     now_time;
      logic [TIME_W-1:0]     delay;
      logic [FIELD_ID_W-1:0] sleeper_id;
      logic                  is_cooperative;
      int                    phase;
   } timer_cmd_type;

   typedef struct {
      logic [TIME_W-1:0]     deadline;
      logic [FIELD_ID_W-1:0] id;
      logic                  coop;
   } sleeper_type;

   typedef struct {
      kind_type              kind;
      logic [FIELD_ID_W-1:0] id;
      logic                  coop;
      logic                  last;
   } wake_report_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;

   timer_cmd_type   timer_cmds[$];
   sleeper_type     sleeper_list[$];
   wake_report_type wake_reports[$];
   timer_cmd_type   offered_cmd;
   wake_report_type due_report;
   int              stall_phase = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   deadline_ordered_timer_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int idle_pct(int ph, bit receiver);
      if (ph == 0) begin
         return receiver ? 45 : 30;
      end else if (ph == 1) begin
         return receiver ? 30 : 45;
      end
      return 0;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   task automatic push_report(kind_type kind, logic [FIELD_ID_W-1:0] id, logic coop,
                              logic last);
      wake_report_type r;
      r.kind = kind;
      r.id   = id;
      r.coop = coop;
      r.last = last;
      wake_reports.push_back(r);
   endtask

   // sorted insert, due pops and flush on the shadow sleeper list
   task automatic apply_timer_command(timer_cmd_type c);
      logic [TIME_W:0] sum;
      sleeper_type     s;
      int              pos;
      int              popped;
      popped = 0;
      if (c.command == CMD_SCHEDULE) begin
         if (c.delay == '0) begin
            push_report(KIND_IMMEDIATE, c.sleeper_id, c.is_cooperative, 1'b1);
         end else if (sleeper_list.size() >= DEFAULT_QUEUE_DEPTH) begin
            push_report(KIND_REJECTED, c.sleeper_id, c.is_cooperative, 1'b1);
         end else begin
            sum        = {1'b0, c.now_time} + {1'b0, c.delay};
            s.deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            s.id       = c.sleeper_id;
            s.coop     = c.is_cooperative;
            pos = 0;
            while (pos < sleeper_list.size() && sleeper_list[pos].deadline <= s.deadline)
               pos++;
            sleeper_list.insert(pos, s);
            push_report(KIND_ACCEPTED, c.sleeper_id, c.is_cooperative, 1'b1);
         end
      end else begin
         if (c.command == CMD_TICK) begin
            while (sleeper_list.size() != 0 && sleeper_list[0].deadline <= c.now_time) begin
               s = sleeper_list.pop_front();
               popped++;
               push_report(KIND_EXPIRED, s.id, s.coop,
                           sleeper_list.size() == 0 ||
                           sleeper_list[0].deadline > c.now_time);
            end
         end else if (c.command == CMD_FLUSH) begin
            while (sleeper_list.size() != 0) begin
               s = sleeper_list.pop_front();
               popped++;
               push_report(KIND_FLUSHED, s.id, s.coop, sleeper_list.size() == 0);
            end
         end
         if (popped == 0)
            push_report(KIND_NONE, '0, 1'b0, 1'b1);
      end
   endtask

   task automatic add_cmd(logic [1:0] command, logic [TIME_W-1:0] now_time,
                          logic [TIME_W-1:0] delay, logic [FIELD_ID_W-1:0] id,
                          logic coop, int ph);
      timer_cmd_type c;
      c.command        = command;
      c.now_time       = now_time;
      c.delay          = delay;
      c.sleeper_id     = id;
      c.is_cooperative = coop;
      c.phase          = ph;
      timer_cmds.push_back(c);
   endtask

   // req driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_timer_command(offered_cmd);
         if (!req_tvalid || req_tready) begin
            if (timer_cmds.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(timer_cmds[0].phase, 1'b0)) begin
               offered_cmd = timer_cmds.pop_front();
               stall_phase = offered_cmd.phase;
               req_tdata  <= {{(REQ_TDATA_W - 145){1'b0}}, offered_cmd.is_cooperative,
                              offered_cmd.sleeper_id, offered_cmd.delay,
                              offered_cmd.now_time};
               req_tuser  <= offered_cmd.command;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (wake_reports.size() == 0) begin
               $error("unexpected rsp transfer: kind %0d id %0h", rsp_tuser,
                      rsp_tdata[FIELD_ID_W-1:0]);
               error_count++;
            end else begin
               due_report = wake_reports.pop_front();
               if (rsp_tuser !== due_report.kind) begin
                  $error("kind: expected %0d, actual %0d", due_report.kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[FIELD_ID_W-1:0] !== due_report.id) begin
                  $error("out_id: expected %0h, actual %0h", due_report.id,
                         rsp_tdata[FIELD_ID_W-1:0]);
                  error_count++;
               end
               if (rsp_tdata[FIELD_ID_W] !== due_report.coop) begin
                  $error("out_cooperative: expected %0b, actual %0b", due_report.coop,
                         rsp_tdata[FIELD_ID_W]);
                  error_count++;
               end
               if (rsp_tlast !== due_report.last) begin
                  $error("last: expected %0b, actual %0b", due_report.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(stall_phase, 1'b1));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      logic [TIME_W-1:0] t_base;
      logic [TIME_W-1:0] now_val;
      logic [TIME_W-1:0] delay_val;
      int                roll;
      int                ph;

      // empty queue, unknown command and zero delay
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, 0);
      add_cmd(CMD_FLUSH, TIME_MAX, TIME_MAX, 16'hFFFF, 1'b1, 0);
      add_cmd(CMD_UNKNOWN, 64'd7, 64'd9, 16'h1234, 1'b1, 0);
      add_cmd(CMD_SCHEDULE, 64'd10, '0, 16'hFFFF, 1'b1, 0);
      // fill to depth: equal deadlines, minimum delay, saturation
      add_cmd(CMD_SCHEDULE, 64'd100, 64'd50, 16'h0001, 1'b0, 0);
      add_cmd(CMD_SCHEDULE, 64'd50, 64'd100, 16'h0002, 1'b1, 0);
      add_cmd(CMD_SCHEDULE, '0, 64'd1, 16'h0000, 1'b0, 0);
      add_cmd(CMD_SCHEDULE, TIME_MAX, TIME_MAX, 16'hFFFF, 1'b1, 0);
      add_cmd(CMD_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFF0, 64'd15, 16'h0005, 1'b0, 0);
      for (int i = 0; i < 11; i++)
         add_cmd(CMD_SCHEDULE, 64'd200, 64'(311 - i * 10), 16'h0100 + 16'(i), i[0], 0);
      // full queue, zero delay while full, then ticks and a flush
      add_cmd(CMD_SCHEDULE, '0, 64'd5, 16'hABCD, 1'b1, 0);
      add_cmd(CMD_SCHEDULE, TIME_MAX, '0, 16'h5A5A, 1'b0, 0);
      add_cmd(CMD_TICK, 64'd150, '0, '0, 1'b0, 0);
      add_cmd(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, 1'b0, 0);
      add_cmd(CMD_FLUSH, '0, '0, '0, 1'b0, 0);

      t_base = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         ph = (n * 3) / RANDOM_ITEMS;
         if (n % (RANDOM_ITEMS / 3) == 0)
            t_base = ($urandom_range(0, 1) != 0) ? rand_time() : {32'h0, $urandom};
         roll = $urandom_range(0, 99);
         now_val = ($urandom_range(0, 99) < 6) ? rand_time() : t_base;
         if (roll < 55) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               delay_val = '0;
            else if (roll < 25)
               delay_val = rand_time();
            else
               delay_val = 64'($urandom_range(1, 2000));
            add_cmd(CMD_SCHEDULE, now_val, delay_val, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), ph);
         end else if (roll < 88) begin
            t_base = t_base + 64'($urandom_range(0, 800));
            add_cmd(CMD_TICK, ($urandom_range(0, 99) < 6) ? rand_time() : t_base,
                    rand_time(), 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    ph);
         end else if (roll < 96) begin
            add_cmd(CMD_FLUSH, rand_time(), rand_time(), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), ph);
         end else begin
            add_cmd(CMD_UNKNOWN, rand_time(), rand_time(), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), ph);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (timer_cmds.size() != 0 || req_tvalid || wake_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
